// File: src/kmd_pkg.sv
// Shared types and constants for the key matrix debounce block.
`timescale 1ns / 1ps
`default_nettype none
package kmd_pkg;

  localparam int CNT_W     = 8;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int LEVEL_W   = 8;
  localparam int MASK_W    = 64;
  localparam int KEY_IDX_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  localparam cfg_idx_t REG_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_PRESENT   = 2'd1;
  localparam cfg_idx_t REG_HALF      = 2'd2;

  localparam cnt_t               THRESHOLD_RST = 8'd5;
  localparam logic [MASK_W-1:0]  PRESENT_RST   = {MASK_W{1'b1}};

endpackage
`default_nettype wire

// File: src/kmd_row_update.sv
// Debounce update of all keys of one scanned row.
`timescale 1ns / 1ps
`default_nettype none
module kmd_row_update #(
  parameter int COLS = 8
) (
  input  wire logic                                  row_ok,
  input  wire logic [COLS-1:0]                       state_i,
  input  wire logic [COLS-1:0][kmd_pkg::CNT_W-1:0]   count_i,
  input  wire logic [COLS-1:0]                       levels_i,
  input  wire logic [COLS-1:0]                       present_i,
  input  wire kmd_pkg::cnt_t                         threshold_i,
  output logic      [COLS-1:0]                       state_o,
  output logic      [COLS-1:0][kmd_pkg::CNT_W-1:0]   count_o,
  output logic      [COLS-1:0]                       fire_o
);

  logic [COLS-1:0][kmd_pkg::CNT_W-1:0] inc;
  logic [COLS-1:0]                     pressed;

  assign pressed = ~levels_i;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      inc[c] = (count_i[c] == kmd_pkg::CNT_MAX) ? kmd_pkg::CNT_MAX
                                                : count_i[c] + kmd_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      state_o[c] = state_i[c];
      count_o[c] = count_i[c];
      fire_o[c]  = 1'b0;
      if (row_ok && present_i[c]) begin
        if (pressed[c] != state_i[c]) begin
          // A threshold of zero is met by the first differing sample.
          if (inc[c] >= threshold_i) begin
            count_o[c] = '0;
            state_o[c] = pressed[c];
            fire_o[c]  = 1'b1;
          end else begin
            count_o[c] = inc[c];
          end
        end else begin
          count_o[c] = '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/key_matrix_debounce_events_unit.sv
// Top level of the key matrix scanner with per-key debounce and event output.
// The first event of a row beat passes the input register, event buffer and output register.
// Throughput: a beat with events holds the event buffer until its last event is loaded, one
// event per cycle unless stalled; a row with no events is taken every cycle while the buffer is free.
// Reset: configuration returns to its defaults, all keys read released, all counts clear.
// The per-row state is held in flip-flops, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module key_matrix_debounce_events_unit #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [2:0] row_index, [10:3] column_levels, [15:11] zero
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [kmd_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: [2:0] event_row, [5:3] event_col, [6] event_half, [7] event_pressed
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [kmd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire kmd_pkg::cfg_idx_t                 cfg_index,
  input  wire logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  kmd_pkg::cnt_t                   thr_r;
  logic [kmd_pkg::MASK_W-1:0]      present_r;
  logic                            half_r;

  logic                            in_valid_r;
  logic [kmd_pkg::ROW_W-1:0]       in_row_r;
  logic [kmd_pkg::LEVEL_W-1:0]     in_lev_r;

  logic [COLS-1:0]                 key_state_r [ROWS];
  logic [COLS-1:0][kmd_pkg::CNT_W-1:0] count_r [ROWS];

  logic                            buf_valid_r;
  logic [COLS-1:0]                 buf_mask_r;
  logic [COLS-1:0]                 buf_press_r;
  logic [kmd_pkg::ROW_W-1:0]       buf_row_r;
  logic                            buf_half_r;

  logic                            out_valid_r;
  logic [kmd_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic                            out_last_r;

  logic                            row_ok;
  logic [RW-1:0]                   row_sel;
  logic [kmd_pkg::KEY_IDX_W-1:0]   key_base;
  logic [COLS-1:0]                 present_row;
  logic [COLS-1:0]                 upd_state;
  logic [COLS-1:0][kmd_pkg::CNT_W-1:0] upd_count;
  logic [COLS-1:0]                 upd_fire;

  logic [kmd_pkg::COL_W-1:0]       pick_col;
  logic                            pick_found;
  logic [COLS-1:0]                 pick_onehot;
  logic [COLS-1:0]                 remain;
  logic                            pick_last;
  logic                            out_load;
  logic                            buf_done;
  logic                            proc_go;

  assign row_ok      = {1'b0, in_row_r} < (kmd_pkg::ROW_W + 1)'(ROWS);
  assign row_sel     = in_row_r[RW-1:0];
  assign key_base    = kmd_pkg::KEY_IDX_W'({3'b000, in_row_r} * 6'(COLS));
  assign present_row = COLS'(present_r >> key_base);

  kmd_row_update #(
    .COLS (COLS)
  ) u_row_update (
    .row_ok      (row_ok),
    .state_i     (key_state_r[row_sel]),
    .count_i     (count_r[row_sel]),
    .levels_i    (in_lev_r[COLS-1:0]),
    .present_i   (present_row),
    .threshold_i (thr_r),
    .state_o     (upd_state),
    .count_o     (upd_count),
    .fire_o      (upd_fire)
  );

  always_comb begin
    pick_col   = '0;
    pick_found = 1'b0;
    for (int c = 0; c < COLS; c++) begin
      if (buf_mask_r[c] && !pick_found) begin
        pick_col   = kmd_pkg::COL_W'(c);
        pick_found = 1'b1;
      end
    end
  end

  assign pick_onehot = buf_mask_r & (~buf_mask_r + COLS'(1));
  assign remain      = buf_mask_r & ~pick_onehot;
  assign pick_last   = (remain == '0);
  assign out_load    = buf_valid_r && (!out_valid_r || out_tready);
  assign buf_done    = out_load && pick_last;
  assign proc_go     = in_valid_r && (!buf_valid_r || buf_done);

  assign in_tready  = !in_valid_r || proc_go;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= kmd_pkg::THRESHOLD_RST;
      present_r   <= kmd_pkg::PRESENT_RST;
      half_r      <= 1'b0;
      in_valid_r  <= 1'b0;
      buf_valid_r <= 1'b0;
      buf_mask_r  <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        key_state_r[r] <= '0;
        count_r[r]     <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kmd_pkg::REG_THRESHOLD: thr_r     <= cfg_data[kmd_pkg::CNT_W-1:0];
          kmd_pkg::REG_PRESENT:   present_r <= cfg_data;
          kmd_pkg::REG_HALF:      half_r    <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (proc_go) begin
        in_valid_r <= 1'b0;
      end

      if (proc_go && row_ok) begin
        key_state_r[row_sel] <= upd_state;
        count_r[row_sel]     <= upd_count;
      end

      if (proc_go) begin
        buf_valid_r <= |upd_fire;
        buf_mask_r  <= upd_fire;
      end else if (out_load) begin
        buf_valid_r <= !pick_last;
        buf_mask_r  <= remain;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_row_r <= in_tdata[kmd_pkg::ROW_W-1:0];
      in_lev_r <= in_tdata[kmd_pkg::ROW_W +: kmd_pkg::LEVEL_W];
    end
    if (proc_go) begin
      buf_press_r <= ~in_lev_r[COLS-1:0];
      buf_row_r   <= in_row_r;
      buf_half_r  <= half_r;
    end
    if (out_load) begin
      out_data_r <= {|(pick_onehot & buf_press_r), buf_half_r, pick_col, buf_row_r};
      out_last_r <= pick_last;
    end
  end

endmodule
`default_nettype wire

// File: src/kmd_checker.sv
// Port-level checker for the key matrix debounce block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module kmd_checker #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [kmd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[2:0]} < 4'(ROWS)) && ({1'b0, out_tdata[5:3]} < 4'(COLS)))
    else $error("event names a key outside the matrix");

  a_row_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[2:0] == $past(out_tdata[2:0]))
      && (out_tdata[6] == $past(out_tdata[6]))
      && (out_tdata[5:3] > $past(out_tdata[5:3])))
    else $error("events of one row beat not contiguous in column order");

endmodule

bind key_matrix_debounce_events_unit kmd_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_kmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
